// File: rtl/core/mips_subset_execute_unit_macros.svh
// Assertion macros shared by the execute unit RTL.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef MIPS_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MSEU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("execute unit check failed");

// Next-cycle implication, checked outside reset.
`define MSEU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("execute unit check failed");

`endif

// File: rtl/core/mseu_pkg.sv
// Shared constants, codes and types of the MIPS subset execute unit.
// Depends on nothing; the ALU, the result queue and the top level refer to it by scoped names.
package mseu_pkg;

    // Storage sizes.
    localparam int MEM_WORDS     = 256;
    localparam int MEM_ADDR_BITS = $clog2(MEM_WORDS);
    localparam int REG_COUNT     = 32;
    localparam int REG_ADDR_BITS = 5;
    localparam int INDEX_BITS    = 16;
    localparam int WORD_BITS     = 32;

    typedef logic [WORD_BITS-1:0]     word_t;
    typedef logic [MEM_ADDR_BITS-1:0] mem_addr_t;
    typedef logic [REG_ADDR_BITS-1:0] reg_addr_t;
    typedef logic [INDEX_BITS-1:0]    index_t;

    // Item operation codes.
    localparam logic [2:0] OPER_EXEC = 3'd0;
    localparam logic [2:0] OPER_WREG = 3'd1;
    localparam logic [2:0] OPER_WMEM = 3'd2;
    localparam logic [2:0] OPER_RREG = 3'd3;
    localparam logic [2:0] OPER_RMEM = 3'd4;

    // Instruction opcodes and R-type functions.
    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_ADDI  = 6'h08;
    localparam logic [5:0] OPC_BEQ   = 6'h04;
    localparam logic [5:0] OPC_BNE   = 6'h05;
    localparam logic [5:0] OPC_LW    = 6'h23;
    localparam logic [5:0] OPC_SW    = 6'h2B;
    localparam logic [5:0] FN_ADD    = 6'h20;
    localparam logic [5:0] FN_SUB    = 6'h22;
    localparam logic [5:0] FN_SLT    = 6'h2A;

    // Status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_UNSUP = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // One result word.
    typedef struct packed {
        word_t       read_value;
        logic [15:0] next_index;
        logic        branch_taken;
        logic [1:0]  status;
    } result_t;

    // Everything the execute logic decides for one item.
    typedef struct packed {
        logic      reg_we;
        reg_addr_t reg_waddr;
        word_t     reg_wdata;
        logic      mem_we;
        mem_addr_t mem_waddr;
        word_t     mem_wdata;
        logic      lw_go;
        mem_addr_t lw_addr;
        reg_addr_t lw_rt;
        logic      idx_we;
        index_t    idx_next;
        result_t   res;
    } alu_out_t;

endpackage

// File: rtl/core/mseu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module mseu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port; a read of the same entry in the same cycle returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mseu_alu.sv
// Decode and execute logic for one item: ALU, address check, branch target.
// Depends on mseu_pkg.
module mseu_alu (
    input  logic [2:0]         oper,
    input  mseu_pkg::word_t    instr,
    input  logic [7:0]         tgt,
    input  mseu_pkg::word_t    wval,
    input  mseu_pkg::word_t    opa,
    input  mseu_pkg::word_t    opb,
    input  mseu_pkg::word_t    dval,
    input  mseu_pkg::index_t   idx,
    output mseu_pkg::alu_out_t result
);

    logic [5:0]             opc;
    logic [5:0]             fn;
    mseu_pkg::reg_addr_t    rt;
    mseu_pkg::reg_addr_t    rd;
    mseu_pkg::word_t        imm;
    mseu_pkg::word_t        addr;
    logic                   addr_oob;
    logic                   tgt_oob_mem;
    logic                   slt;
    logic                   eq;
    mseu_pkg::index_t       idx_inc;

    // Field split and address arithmetic shared by several instructions.
    assign opc  = instr[31:26];
    assign fn   = instr[5:0];
    assign rt   = instr[20:16];
    assign rd   = instr[15:11];
    assign imm  = {{16{instr[15]}}, instr[15:0]};
    assign addr = opa + imm;
    assign addr_oob = addr[31] ||
                      ({2'b00, addr[31:2]} >= 32'(mseu_pkg::MEM_WORDS));
    assign tgt_oob_mem = {24'd0, tgt} >= 32'(mseu_pkg::MEM_WORDS);
    assign slt = (opa ^ 32'h8000_0000) < (opb ^ 32'h8000_0000);
    assign eq  = opa == opb;
    assign idx_inc = idx + mseu_pkg::index_t'(1);

    always_comb
    begin
        result                  = '0;
        result.res.next_index   = 16'(idx);
        result.res.status       = mseu_pkg::STATUS_OK;
        result.lw_addr          = mseu_pkg::mem_addr_t'(addr[31:2]);
        result.lw_rt            = rt;
        result.idx_next         = idx_inc;

        unique case (oper)
            mseu_pkg::OPER_EXEC:
            begin
                result.idx_we = 1'b1;
                unique case (opc)
                    mseu_pkg::OPC_RTYPE:
                    begin
                        result.reg_waddr = rd;
                        unique case (fn)
                            mseu_pkg::FN_ADD:
                            begin
                                result.reg_we    = rd != '0;
                                result.reg_wdata = opa + opb;
                            end
                            mseu_pkg::FN_SUB:
                            begin
                                result.reg_we    = rd != '0;
                                result.reg_wdata = opa - opb;
                            end
                            mseu_pkg::FN_SLT:
                            begin
                                result.reg_we    = rd != '0;
                                result.reg_wdata = {31'd0, slt};
                            end
                            default:
                            begin
                                result.res.status = mseu_pkg::STATUS_UNSUP;
                            end
                        endcase
                    end
                    mseu_pkg::OPC_ADDI:
                    begin
                        result.reg_we    = rt != '0;
                        result.reg_waddr = rt;
                        result.reg_wdata = addr;
                    end
                    mseu_pkg::OPC_LW:
                    begin
                        // The load itself finishes in the memory stage.
                        if (addr_oob)
                        begin
                            result.res.status = mseu_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            result.lw_go = 1'b1;
                        end
                    end
                    mseu_pkg::OPC_SW:
                    begin
                        if (addr_oob)
                        begin
                            result.res.status = mseu_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            result.mem_we    = 1'b1;
                            result.mem_waddr = mseu_pkg::mem_addr_t'(addr[31:2]);
                            result.mem_wdata = opb;
                        end
                    end
                    mseu_pkg::OPC_BEQ,
                    mseu_pkg::OPC_BNE:
                    begin
                        if ((opc == mseu_pkg::OPC_BEQ) ? eq : !eq)
                        begin
                            result.res.branch_taken = 1'b1;
                            result.idx_next = idx_inc + mseu_pkg::index_t'(imm);
                        end
                    end
                    default:
                    begin
                        result.res.status = mseu_pkg::STATUS_UNSUP;
                    end
                endcase
                result.res.next_index = 16'(result.idx_next);
            end
            mseu_pkg::OPER_WREG,
            mseu_pkg::OPER_RREG:
            begin
                if (tgt > 8'd31)
                begin
                    result.res.status = mseu_pkg::STATUS_RANGE;
                end
                else if (oper == mseu_pkg::OPER_WREG)
                begin
                    result.reg_we    = tgt[4:0] != '0;
                    result.reg_waddr = tgt[4:0];
                    result.reg_wdata = wval;
                end
                else
                begin
                    result.res.read_value = opa;
                end
            end
            mseu_pkg::OPER_WMEM,
            mseu_pkg::OPER_RMEM:
            begin
                if (tgt_oob_mem)
                begin
                    result.res.status = mseu_pkg::STATUS_RANGE;
                end
                else if (oper == mseu_pkg::OPER_WMEM)
                begin
                    result.mem_we    = 1'b1;
                    result.mem_waddr = mseu_pkg::mem_addr_t'(tgt);
                    result.mem_wdata = wval;
                end
                else
                begin
                    result.res.read_value = dval;
                end
            end
            default:
            begin
                result.res.status = mseu_pkg::STATUS_UNSUP;
            end
        endcase
    end

endmodule

// File: rtl/core/mseu_result_fifo.sv
// Two-entry result queue that decouples the execute pipeline from the receiver.
// Depends on mseu_pkg.
module mseu_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mseu_pkg::result_t push_data,
    input  logic              pop_ready,
    output logic              head_valid,
    output mseu_pkg::result_t head_data,
    output logic [1:0]        count
);

    mseu_pkg::result_t entry_reg [2];
    logic              wptr_reg;
    logic              rptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              pop;

    assign head_valid = count_reg != 2'd0;
    assign head_data  = entry_reg[rptr_reg];
    assign pop        = head_valid && pop_ready;
    assign count      = count_reg;

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/mips_subset_execute_unit.sv
// Top level of the MIPS subset execute unit: stream ports, pipeline, storage.
// Depends on mseu_pkg, mseu_ram, mseu_alu, mseu_result_fifo and the macro header.
//
// Usage: each input word carries an operation in s_axis_tuser (execute an
// instruction, write or read a register, write or read a data memory word)
// and its operands in s_axis_tdata. Every accepted word yields exactly one
// output word, in order: read value, next instruction index and branch flag
// in m_axis_tdata, status in m_axis_tuser.
// A result passes the execute stage registers and the result queue; a load
// also passes the memory stage, whose memory read follows the register read.
// A new word is taken while an earlier one is in flight only if the result
// queue is empty; a load holds the input while the data memory is read.
// The register file and the data memory are synchronous RAMs read in the
// accept cycle; a write in that same cycle is forwarded.
// Reset clears all control state and per-entry valid bits, so every register,
// memory word and the instruction index read as zero; no clearing pass runs.
// When the receiver stalls, up to two results wait in the queue and the input
// is held off; nothing is dropped.
`include "mips_subset_execute_unit_macros.svh"

module mips_subset_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] instr_word, [39:32] target_index, [71:40] write_value
    input  logic [71:0] s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] read_value, [47:32] next_index, [48] branch_taken, [55:49] zero
    output logic [55:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser
);

    mseu_pkg::word_t      in_instr;
    logic [7:0]           in_tgt;
    mseu_pkg::word_t      in_wval;
    logic                 in_fire;
    mseu_pkg::reg_addr_t  ra_addr;
    mseu_pkg::reg_addr_t  rb_addr;
    mseu_pkg::mem_addr_t  dm_raddr;
    mseu_pkg::mem_addr_t  in_maddr;

    // Execute stage registers.
    logic                 e_valid_reg;
    logic [2:0]           e_oper_reg;
    mseu_pkg::word_t      e_instr_reg;
    logic [7:0]           e_tgt_reg;
    mseu_pkg::word_t      e_wval_reg;
    logic                 e_a_fwd_reg;
    mseu_pkg::word_t      e_a_fdat_reg;
    logic                 e_a_live_reg;
    logic                 e_b_fwd_reg;
    mseu_pkg::word_t      e_b_fdat_reg;
    logic                 e_b_live_reg;
    logic                 e_d_fwd_reg;
    mseu_pkg::word_t      e_d_fdat_reg;
    logic                 e_d_live_reg;
    logic                 e_is_lw;

    // Memory stage registers for loads.
    logic                 m_valid_reg;
    mseu_pkg::reg_addr_t  m_rt_reg;
    logic [15:0]          m_next_reg;
    logic                 m_live_reg;
    mseu_pkg::word_t      m_ldata;

    mseu_pkg::index_t     idx_reg;
    logic [mseu_pkg::REG_COUNT-1:0] rvalid_reg;
    logic [mseu_pkg::REG_COUNT-1:0] rvalid_next;
    logic [mseu_pkg::MEM_WORDS-1:0] dvalid_reg;
    logic [mseu_pkg::MEM_WORDS-1:0] dvalid_next;

    mseu_pkg::word_t      ra_rdata;
    mseu_pkg::word_t      rb_rdata;
    mseu_pkg::word_t      dm_rdata;
    mseu_pkg::word_t      opa;
    mseu_pkg::word_t      opb;
    mseu_pkg::word_t      dval;
    mseu_pkg::alu_out_t   alu_out;

    logic                 reg_we;
    mseu_pkg::reg_addr_t  reg_waddr;
    mseu_pkg::word_t      reg_wdata;
    logic                 mem_we;

    logic                 res_push;
    mseu_pkg::result_t    res_data;
    mseu_pkg::result_t    m_res;
    mseu_pkg::result_t    head_data;
    logic [1:0]           fifo_count;
    logic                 busy;

    // Input unpacking and handshake.
    assign in_instr = s_axis_tdata[31:0];
    assign in_tgt   = s_axis_tdata[39:32];
    assign in_wval  = s_axis_tdata[71:40];
    assign busy     = e_valid_reg || m_valid_reg;
    assign e_is_lw  = (e_oper_reg == mseu_pkg::OPER_EXEC) &&
                      (e_instr_reg[31:26] == mseu_pkg::OPC_LW);
    assign s_axis_tready = !(e_valid_reg && e_is_lw) &&
                           ((fifo_count == 2'd0) || ((fifo_count == 2'd1) && !busy));
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Read addresses issued in the accept cycle; a load reads data memory later.
    assign ra_addr  = (s_axis_tuser == mseu_pkg::OPER_EXEC) ? in_instr[25:21] : in_tgt[4:0];
    assign rb_addr  = in_instr[20:16];
    assign in_maddr = mseu_pkg::mem_addr_t'(in_tgt);
    assign dm_raddr = (e_valid_reg && e_is_lw) ? alu_out.lw_addr : in_maddr;

    // Write ports: the execute stage, or the memory stage for a load.
    assign m_ldata   = m_live_reg ? dm_rdata : '0;
    assign reg_we    = (e_valid_reg && alu_out.reg_we) || (m_valid_reg && (m_rt_reg != '0));
    assign reg_waddr = m_valid_reg ? m_rt_reg : alu_out.reg_waddr;
    assign reg_wdata = m_valid_reg ? m_ldata : alu_out.reg_wdata;
    assign mem_we    = e_valid_reg && alu_out.mem_we;

    mseu_ram #(
        .WIDTH (mseu_pkg::WORD_BITS),
        .DEPTH (mseu_pkg::REG_COUNT)
    ) u_rf_a (
        .clk   (clk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .raddr (ra_addr),
        .rdata (ra_rdata)
    );

    mseu_ram #(
        .WIDTH (mseu_pkg::WORD_BITS),
        .DEPTH (mseu_pkg::REG_COUNT)
    ) u_rf_b (
        .clk   (clk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .raddr (rb_addr),
        .rdata (rb_rdata)
    );

    mseu_ram #(
        .WIDTH (mseu_pkg::WORD_BITS),
        .DEPTH (mseu_pkg::MEM_WORDS)
    ) u_dmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (alu_out.mem_waddr),
        .wdata (alu_out.mem_wdata),
        .raddr (dm_raddr),
        .rdata (dm_rdata)
    );

    // Operand select: forwarded write, stored entry, or zero if never written.
    assign opa  = e_a_fwd_reg ? e_a_fdat_reg : (e_a_live_reg ? ra_rdata : '0);
    assign opb  = e_b_fwd_reg ? e_b_fdat_reg : (e_b_live_reg ? rb_rdata : '0);
    assign dval = e_d_fwd_reg ? e_d_fdat_reg : (e_d_live_reg ? dm_rdata : '0);

    mseu_alu u_alu (
        .oper   (e_oper_reg),
        .instr  (e_instr_reg),
        .tgt    (e_tgt_reg),
        .wval   (e_wval_reg),
        .opa    (opa),
        .opb    (opb),
        .dval   (dval),
        .idx    (idx_reg),
        .result (alu_out)
    );

    // Valid bits mark entries written since reset.
    always_comb
    begin
        rvalid_next = rvalid_reg;
        dvalid_next = dvalid_reg;
        if (reg_we)
        begin
            rvalid_next[reg_waddr] = 1'b1;
        end
        if (mem_we)
        begin
            dvalid_next[alu_out.mem_waddr] = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            rvalid_reg  <= '0;
            dvalid_reg  <= '0;
        end
        else
        begin
            e_valid_reg <= in_fire;
            m_valid_reg <= e_valid_reg && alu_out.lw_go;
            rvalid_reg  <= rvalid_next;
            dvalid_reg  <= dvalid_next;
            if (e_valid_reg && alu_out.idx_we)
            begin
                idx_reg <= alu_out.idx_next;
            end
        end
    end

    // Stage payload, including forwarding of writes made in the accept cycle.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            e_oper_reg   <= s_axis_tuser;
            e_instr_reg  <= in_instr;
            e_tgt_reg    <= in_tgt;
            e_wval_reg   <= in_wval;
            e_a_fwd_reg  <= reg_we && (reg_waddr == ra_addr);
            e_a_fdat_reg <= reg_wdata;
            e_a_live_reg <= rvalid_reg[ra_addr];
            e_b_fwd_reg  <= reg_we && (reg_waddr == rb_addr);
            e_b_fdat_reg <= reg_wdata;
            e_b_live_reg <= rvalid_reg[rb_addr];
            e_d_fwd_reg  <= mem_we && (alu_out.mem_waddr == in_maddr);
            e_d_fdat_reg <= alu_out.mem_wdata;
            e_d_live_reg <= dvalid_reg[in_maddr];
        end
        if (e_valid_reg)
        begin
            m_rt_reg   <= alu_out.lw_rt;
            m_next_reg <= alu_out.res.next_index;
            m_live_reg <= dvalid_reg[alu_out.lw_addr];
        end
    end

    // Result from the execute stage, or from the memory stage for a load.
    always_comb
    begin
        m_res              = '0;
        m_res.next_index   = m_next_reg;
        m_res.status       = mseu_pkg::STATUS_OK;
    end

    assign res_push = m_valid_reg || (e_valid_reg && !alu_out.lw_go);
    assign res_data = m_valid_reg ? m_res : alu_out.res;

    mseu_result_fifo u_out_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_push),
        .push_data  (res_data),
        .pop_ready  (m_axis_tready),
        .head_valid (m_axis_tvalid),
        .head_data  (head_data),
        .count      (fifo_count)
    );

    // Output packing.
    assign m_axis_tdata = {7'd0, head_data.branch_taken, head_data.next_index,
                           head_data.read_value};
    assign m_axis_tuser = head_data.status;

    // Pipeline checks.
    `MSEU_ASSERT_IMPL(a_stage_excl, e_valid_reg, !m_valid_reg)
    `MSEU_ASSERT_NEXT(a_lw_to_mem, e_valid_reg && alu_out.lw_go, m_valid_reg && !e_valid_reg)
    `MSEU_ASSERT_IMPL(a_queue_room, res_push, fifo_count != 2'd2)
    `MSEU_ASSERT_IMPL(a_r0_kept, reg_we, reg_waddr != '0)

endmodule
